>>> rtl/shamh_pkg.sv
// Shared types, constants and round functions of the SHA-256 message hash.
package shamh_pkg;

  // Default depth of the word queue between packer and round engine.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [3:0] DIGEST_WORDS = 4'd8;

  // One message word on its way to the round engine.
  typedef struct packed {
    logic [31:0] word;
    logic        last;   // final word of the padded message
  } msg_word_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_PAD_HEAD,
    FR_PAD_FILL,
    FR_LEN_HI,
    FR_LEN_LO
  } front_state_t;

  typedef enum logic {
    CR_ROUND,
    CR_FINAL
  } core_state_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    big_sigma0 = ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    big_sigma1 = ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    small_sigma0 = ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    small_sigma1 = ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
  endfunction

  // Initial hash value, word i.
  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0:    init_hash = 32'h6a09e667;
      3'd1:    init_hash = 32'hbb67ae85;
      3'd2:    init_hash = 32'h3c6ef372;
      3'd3:    init_hash = 32'ha54ff53a;
      3'd4:    init_hash = 32'h510e527f;
      3'd5:    init_hash = 32'h9b05688c;
      3'd6:    init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  // Round constant table.
  function automatic logic [31:0] round_k(input logic [5:0] i);
    case (i)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

>>> rtl/shamh_front.sv
// Byte packer and padding sequencer: turns the byte stream into message words.
module shamh_front
  import shamh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_byte,
  input  logic       in_end_of_message,
  output logic       q_push,
  output msg_word_t  q_data,
  input  logic       q_full
);

  front_state_t state_r, state_nxt;
  logic [31:0]  word_r, word_nxt;
  logic [1:0]   byte_pos_r, byte_pos_nxt;
  logic [3:0]   word_cnt_r, word_cnt_nxt;
  logic [63:0]  len_r, len_nxt;
  logic         accept;
  logic [31:0]  pad_word;

  assign full   = (state_r != FR_IDLE) || q_full;
  assign accept = push && !full;

  // Partial word closed by the 0x80 marker and zero fill.
  always_comb begin
    case (byte_pos_r)
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {word_r[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {word_r[15:0], PAD_BYTE, 8'h0};
      default: pad_word = {word_r[23:0], PAD_BYTE};
    endcase
  end

  // Next state and queue writes.
  always_comb begin
    state_nxt    = state_r;
    word_nxt     = word_r;
    byte_pos_nxt = byte_pos_r;
    word_cnt_nxt = word_cnt_r;
    len_nxt      = len_r;
    q_push       = 1'b0;
    q_data       = '{word: 32'h0, last: 1'b0};
    case (state_r)
      FR_IDLE: begin
        if (accept && in_has_byte) begin
          word_nxt = {word_r[23:0], in_data_byte};
          len_nxt  = len_r + 64'd8;
          if (byte_pos_r == 2'd3) begin
            q_push       = 1'b1;
            q_data       = '{word: word_nxt, last: 1'b0};
            word_cnt_nxt = word_cnt_r + 4'd1;
          end
          byte_pos_nxt = byte_pos_r + 2'd1;
        end
        if (accept && in_end_of_message) begin
          state_nxt = FR_PAD_HEAD;
        end
      end
      FR_PAD_HEAD: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_data       = '{word: pad_word, last: 1'b0};
          word_cnt_nxt = word_cnt_r + 4'd1;
          state_nxt    = (word_cnt_r == 4'd13) ? FR_LEN_HI : FR_PAD_FILL;
        end
      end
      FR_PAD_FILL: begin
        if (!q_full) begin
          q_push       = 1'b1;
          word_cnt_nxt = word_cnt_r + 4'd1;
          if (word_cnt_r == 4'd13) begin
            state_nxt = FR_LEN_HI;
          end
        end
      end
      FR_LEN_HI: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_data       = '{word: len_r[63:32], last: 1'b0};
          word_cnt_nxt = word_cnt_r + 4'd1;
          state_nxt    = FR_LEN_LO;
        end
      end
      FR_LEN_LO: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_data       = '{word: len_r[31:0], last: 1'b1};
          word_cnt_nxt = 4'd0;
          byte_pos_nxt = 2'd0;
          len_nxt      = 64'd0;
          state_nxt    = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FR_IDLE;
      byte_pos_r <= 2'd0;
      word_cnt_r <= 4'd0;
      len_r      <= 64'd0;
    end else begin
      state_r    <= state_nxt;
      byte_pos_r <= byte_pos_nxt;
      word_cnt_r <= word_cnt_nxt;
      len_r      <= len_nxt;
    end
  end

  // Byte assembly register needs no reset.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

>>> rtl/shamh_queue.sv
// Short word queue between the packer and the round engine.
module shamh_queue
  import shamh_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  msg_word_t wr_data,
  output logic      q_full,
  output logic      rd_valid,
  output msg_word_t rd_data,
  input  logic      rd_en
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  msg_word_t         mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_wr, do_rd;

  assign q_full   = (cnt_r == DEPTH_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/shamh_core.sv
// Round engine: message schedule, 64 compression rounds, hash update, digest out.
module shamh_core
  import shamh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  msg_word_t   q_data,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  core_state_t state_r, state_nxt;
  logic [5:0]  rnd_r;
  logic        final_r;
  logic [31:0] hash_r [8];
  logic [31:0] work_r [8];
  logic [31:0] sched_r [16];
  logic [31:0] dig_r [8];
  logic [3:0]  dig_cnt_r;

  logic        early;
  logic        step;
  logic        dig_load;
  logic        dig_pop;
  logic [31:0] wt;
  logic [31:0] t1, t2;
  logic [31:0] sum [8];

  assign early = (rnd_r[5:4] == 2'b00);
  assign step  = (state_r == CR_ROUND) && (!early || q_valid);
  assign q_pop = (state_r == CR_ROUND) && early && q_valid;

  // Schedule word for this round.
  always_comb begin
    if (early) begin
      wt = q_data.word;
    end else begin
      wt = sched_r[0] + small_sigma0(sched_r[1]) + sched_r[9] + small_sigma1(sched_r[14]);
    end
  end

  // One compression round.
  assign t1 = work_r[7] + big_sigma1(work_r[4])
            + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
            + round_k(rnd_r) + wt;
  assign t2 = big_sigma0(work_r[0])
            + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = hash_r[i] + work_r[i];
    end
  end

  assign dig_load = (state_r == CR_FINAL) && final_r && (dig_cnt_r == 4'd0);
  assign dig_pop  = pop && !empty;

  // Round and update sequencing.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CR_ROUND: begin
        if (step && rnd_r == 6'd63) begin
          state_nxt = CR_FINAL;
        end
      end
      CR_FINAL: begin
        if (!final_r || dig_load) begin
          state_nxt = CR_ROUND;
        end
      end
      default: state_nxt = CR_ROUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CR_ROUND;
      rnd_r     <= 6'd0;
      final_r   <= 1'b0;
      dig_cnt_r <= 4'd0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= init_hash(3'(i));
        work_r[i] <= init_hash(3'(i));
      end
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_data.last) begin
        final_r <= 1'b1;
      end
      if (step) begin
        rnd_r     <= rnd_r + 6'd1;
        work_r[0] <= t1 + t2;
        work_r[1] <= work_r[0];
        work_r[2] <= work_r[1];
        work_r[3] <= work_r[2];
        work_r[4] <= work_r[3] + t1;
        work_r[5] <= work_r[4];
        work_r[6] <= work_r[5];
        work_r[7] <= work_r[6];
      end
      // Block done: fold into the hash, or hand out the digest and restart.
      if (state_r == CR_FINAL && !final_r) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= sum[i];
          work_r[i] <= sum[i];
        end
      end
      if (dig_load) begin
        final_r <= 1'b0;
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= init_hash(3'(i));
          work_r[i] <= init_hash(3'(i));
        end
      end
      if (dig_load) begin
        dig_cnt_r <= DIGEST_WORDS;
      end else if (dig_pop) begin
        dig_cnt_r <= dig_cnt_r - 4'd1;
      end
    end
  end

  // Schedule window and digest shift register carry payload only.
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[15] <= wt;
    end
    if (dig_load) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= sum[i];
      end
    end else if (dig_pop) begin
      for (int i = 0; i < 7; i++) begin
        dig_r[i] <= dig_r[i + 1];
      end
    end
  end

  assign empty           = (dig_cnt_r == 4'd0);
  assign out_digest_word = dig_r[0];
  assign out_word_index  = 3'(DIGEST_WORDS - dig_cnt_r);
  assign out_last_word   = (dig_cnt_r == 4'd1);

endmodule

>>> rtl/sha256_message_hash.sv
// Top level of the streaming SHA-256 message hash.
//
// SHA-256 over a byte stream, one byte per input transaction; a transaction with
// end_of_message set (with or without a byte) closes the message and yields eight
// digest words, word 0 first. Bytes are taken one per cycle while the word queue
// has room. The round engine spends 64 rounds plus a hash update on each block,
// and only its first 16 rounds take words from the queue (four words by default);
// on a continuous stream the queue fills during the other 48 rounds and the
// update, and the input then holds full. Long message throughput is therefore
// set by the queue depth against the round engine. After end_of_message the input
// holds full while the padding sequencer writes the closing and length words, 3 to
// 18 words at one a cycle and never faster than the engine drains the queue; the
// first digest word is ready once the engine has hashed the last block, which is
// the current block when the closing and length words fit in it and one more
// block when they do not. The digest sits in its own output register: the next
// message may stream in while it is read, and only a second digest waits until
// all eight words have been popped.
module sha256_message_hash
  import shamh_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic      q_push;
  msg_word_t q_wdata;
  logic      q_full;
  logic      q_valid;
  msg_word_t q_rdata;
  logic      q_pop;

  shamh_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .q_push            (q_push),
    .q_data            (q_wdata),
    .q_full            (q_full)
  );

  shamh_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .q_full   (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_rdata),
    .rd_en    (q_pop)
  );

  shamh_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
